[rtl/ibs_pkg.sv]
// ----------------------------------------------------------------------------
// ibs_pkg
// Shared widths, codes and the result word type of the interval bracket
// search unit.
// ----------------------------------------------------------------------------
package ibs_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W  = 6;
    localparam int STAT_W = 2;
    localparam int CFG_W  = 7;
    localparam int SLOT_W = 6;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_INSIDE = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_BELOW  = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_ABOVE  = 2'd2;

    localparam logic [CFG_W-1:0] ENTRIES_RESET = 7'd2;

    typedef struct packed {
        logic [IDX_W-1:0]  lower;
        logic [IDX_W-1:0]  upper;
        logic [STAT_W-1:0] status;
    } ibs_result_t;

endpackage

[rtl/ibs_table_ram.sv]
// ----------------------------------------------------------------------------
// ibs_table_ram
// Breakpoint table: one write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module ibs_table_ram
    import ibs_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [ADDR_W-1:0]        wr_addr,
    input  logic signed [DATA_W-1:0] wr_data,
    input  logic                     rd_en,
    input  logic [ADDR_W-1:0]        rd_addr,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/ibs_scan_engine.sv]
// ----------------------------------------------------------------------------
// ibs_scan_engine
// Walks the entries in use one per cycle, tracking minimum, maximum and the
// first entry above the query value, then forms the bracket word.
// ----------------------------------------------------------------------------
module ibs_scan_engine
    import ibs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    parameter int ADDR_W      = 6
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [DATA_W-1:0] query_value,
    input  logic [CFG_W-1:0]         entries_in_use,
    output logic                     idle,
    output logic                     rd_en,
    output logic [ADDR_W-1:0]        rd_addr,
    input  logic signed [DATA_W-1:0] rd_data,
    output logic                     res_valid,
    output ibs_result_t              res_word,
    input  logic                     res_take
);

    localparam int I_W = (ADDR_W < CFG_W) ? ADDR_W : CFG_W;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t                   state_reg, state_next;
    logic [I_W-1:0]           issue_idx_reg, issue_idx_next;
    logic                     issue_run_reg, issue_run_next;
    logic                     data_valid_reg, data_valid_next;
    logic [I_W-1:0]           data_idx_reg, data_idx_next;
    logic [I_W-1:0]           last_reg, last_next;
    logic signed [DATA_W-1:0] x_reg, x_next;
    logic signed [DATA_W-1:0] mn_reg, mn_next;
    logic signed [DATA_W-1:0] mx_reg, mx_next;
    logic                     found_reg, found_next;
    logic [I_W-1:0]           k_reg, k_next;

    logic [CFG_W-1:0]         cfg_m1;
    logic                     first_elem;

    assign cfg_m1     = entries_in_use - CFG_W'(1);
    assign first_elem = (data_idx_reg == '0);

    assign idle      = (state_reg == ST_IDLE);
    assign rd_en     = (state_reg == ST_SCAN) && issue_run_reg;
    assign rd_addr   = ADDR_W'(issue_idx_reg);
    assign res_valid = (state_reg == ST_FINISH);

    always_comb
    begin
        state_next      = state_reg;
        issue_idx_next  = issue_idx_reg;
        issue_run_next  = issue_run_reg;
        data_valid_next = rd_en;
        data_idx_next   = issue_idx_reg;
        last_next       = last_reg;
        x_next          = x_reg;
        mn_next         = mn_reg;
        mx_next         = mx_reg;
        found_next      = found_reg;
        k_next          = k_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // Entry count is clamped to the range 2 .. TABLE_DEPTH.
                    if (entries_in_use < CFG_W'(2))
                    begin
                        last_next = I_W'(1);
                    end
                    else if (32'(entries_in_use) > TABLE_DEPTH)
                    begin
                        last_next = I_W'(TABLE_DEPTH - 1);
                    end
                    else
                    begin
                        last_next = I_W'(cfg_m1);
                    end
                    x_next         = query_value;
                    issue_idx_next = '0;
                    issue_run_next = 1'b1;
                    found_next     = 1'b0;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (issue_run_reg)
                begin
                    if (issue_idx_reg == last_reg)
                    begin
                        issue_run_next = 1'b0;
                    end
                    else
                    begin
                        issue_idx_next = issue_idx_reg + I_W'(1);
                    end
                end
                if (data_valid_reg)
                begin
                    if (first_elem || (rd_data < mn_reg))
                    begin
                        mn_next = rd_data;
                    end
                    if (first_elem || (rd_data > mx_reg))
                    begin
                        mx_next = rd_data;
                    end
                    // The last entry in use never counts as the first one above.
                    if (!found_reg && (data_idx_reg != last_reg) && (rd_data > x_reg))
                    begin
                        found_next = 1'b1;
                        k_next     = data_idx_reg;
                    end
                    if (data_idx_reg == last_reg)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end
            ST_FINISH:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_word.lower  = '0;
        res_word.upper  = '0;
        res_word.status = STATUS_INSIDE;
        if (x_reg < mn_reg)
        begin
            res_word.status = STATUS_BELOW;
        end
        else if (x_reg > mx_reg)
        begin
            res_word.status = STATUS_ABOVE;
        end
        else if ((x_reg == mn_reg) || (found_reg && (k_reg == '0)))
        begin
            res_word.upper = IDX_W'(1);
        end
        else if (found_reg)
        begin
            res_word.lower = IDX_W'(k_reg - I_W'(1));
            res_word.upper = IDX_W'(k_reg);
        end
        else
        begin
            res_word.lower = IDX_W'(last_reg - I_W'(1));
            res_word.upper = IDX_W'(last_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_run_reg  <= 1'b0;
            data_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_run_reg  <= issue_run_next;
            data_valid_reg <= data_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= issue_idx_next;
        data_idx_reg  <= data_idx_next;
        last_reg      <= last_next;
        x_reg         <= x_next;
        mn_reg        <= mn_next;
        mx_reg        <= mx_next;
        found_reg     <= found_next;
        k_reg         <= k_next;
    end

endmodule

[rtl/interval_bracket_search_unit.sv]
// ----------------------------------------------------------------------------
// interval_bracket_search_unit
// Ascending breakpoint table with load and bracket query words.
//
//   Channel  | Signals                                         | Dir
//   ---------+-------------------------------------------------+-----
//   input    | in_valid, in_ready, opcode, entry_index,        | in
//            | sample_value                                    |
//   output   | out_valid, out_ready, lower_index, upper_index, | out
//            | position_status                                 |
//   config   | cfg_write_en, cfg_write_data                    | in
//
// A load word is written on accept. A query word sweeps the N entries in use
// (N being the clamped entry count) through the single read port of the
// table, one entry per cycle, before its result reaches the result register.
// Reset clears control state only; table contents are undefined until loaded.
// The next word is accepted once the engine is idle; a result waiting in the
// output register stalls only the following query at its last step.
// ----------------------------------------------------------------------------
module interval_bracket_search_unit
    import ibs_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [SLOT_W-1:0]        entry_index,
    input  logic signed [DATA_W-1:0] sample_value,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [IDX_W-1:0]         lower_index,
    output logic [IDX_W-1:0]         upper_index,
    output logic [STAT_W-1:0]        position_status,
    input  logic                     cfg_write_en,
    input  logic [CFG_W-1:0]         cfg_write_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [CFG_W-1:0]         entries_reg;
    logic                     out_valid_reg, out_valid_next;
    ibs_result_t              out_word_reg;

    logic                     in_accept;
    logic                     load_wr;
    logic                     query_start;
    logic                     engine_idle;
    logic                     rd_en;
    logic [ADDR_W-1:0]        rd_addr;
    logic signed [DATA_W-1:0] rd_data;
    logic                     res_valid;
    ibs_result_t              res_word;
    logic                     res_take;

    assign in_ready    = engine_idle;
    assign in_accept   = in_valid && in_ready;
    assign query_start = in_accept && (opcode == OP_QUERY);
    // Loads only land while the engine is idle, so no read can race a write.
    assign load_wr     = in_accept && (opcode == OP_LOAD)
                         && (32'(entry_index) < TABLE_DEPTH);

    ibs_table_ram #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .clk     (clk),
        .wr_en   (load_wr),
        .wr_addr (ADDR_W'(entry_index)),
        .wr_data (sample_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ibs_scan_engine #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_W      (ADDR_W)
    ) u_engine (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (query_start),
        .query_value    (sample_value),
        .entries_in_use (entries_reg),
        .idle           (engine_idle),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .res_valid      (res_valid),
        .res_word       (res_word),
        .res_take       (res_take)
    );

    assign res_take = res_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_reg   <= ENTRIES_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                entries_reg <= cfg_write_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_word_reg <= res_word;
        end
    end

    assign out_valid       = out_valid_reg;
    assign lower_index     = out_word_reg.lower;
    assign upper_index     = out_word_reg.upper;
    assign position_status = out_word_reg.status;

    // An out-of-range result carries zero indices.
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (position_status != STATUS_INSIDE))
            |-> ((lower_index == '0) && (upper_index == '0)))
        else $error("out-of-range result with nonzero indices");

    // An inside result always names two neighboring entries.
    a_inside_adjacent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (position_status == STATUS_INSIDE))
            |-> (upper_index == IDX_W'(lower_index + IDX_W'(1))))
        else $error("inside result indices are not adjacent");

    // A query keeps the input side closed in the following cycle.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (opcode == OP_QUERY)) |=> !in_ready)
        else $error("input accepted while a query scan is running");

endmodule

[tb/tb_interval_bracket_search_unit.sv]
// ----------------------------------------------------------------------------
// tb_interval_bracket_search_unit
// Self-checking bench for the interval bracket search unit. Tables are loaded
// word by word and queried with values taken from the table, its neighbors,
// the range extremes and random data. A predictor class tracks the table and
// the entry count and checks each result word against the oldest expected
// bracket. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
import ibs_pkg::*;

localparam int TABLE_SLOTS = 64;

class bracket_predictor;

    logic signed [DATA_W-1:0] breakpoints [TABLE_SLOTS];
    logic [CFG_W-1:0]         entry_count;
    ibs_result_t              expected_brackets [$];
    int                       mismatch_count;

    function new();
        entry_count    = ENTRIES_RESET;
        mismatch_count = 0;
    endfunction

    // The block clamps the entry count to the range the table can hold.
    function int live_entries();
        int n;
        n = int'(entry_count);
        if (n < 2)
            n = 2;
        if (n > TABLE_SLOTS)
            n = TABLE_SLOTS;
        return n;
    endfunction

    function void set_entry_count(logic [CFG_W-1:0] value);
        entry_count = value;
    endfunction

    function ibs_result_t locate(logic signed [DATA_W-1:0] x);
        int                       n;
        bit                       found;
        logic signed [DATA_W-1:0] lowest;
        logic signed [DATA_W-1:0] highest;
        ibs_result_t              r;
        n       = live_entries();
        found   = 1'b0;
        lowest  = breakpoints[0];
        highest = breakpoints[0];
        for (int i = 1; i < n; i++)
        begin
            if (breakpoints[i] < lowest)
                lowest = breakpoints[i];
            if (breakpoints[i] > highest)
                highest = breakpoints[i];
        end
        r.lower  = '0;
        r.upper  = '0;
        r.status = STATUS_INSIDE;
        if (x < lowest)
            r.status = STATUS_BELOW;
        else if (x > highest)
            r.status = STATUS_ABOVE;
        else if (x == lowest)
            r.upper = IDX_W'(1);
        else
        begin
            r.lower = IDX_W'(n - 2);
            r.upper = IDX_W'(n - 1);
            // An unsorted table can put the first larger entry at index zero.
            for (int i = 0; i < n - 1; i++)
            begin
                if (!found && breakpoints[i] > x)
                begin
                    found   = 1'b1;
                    r.lower = (i == 0) ? IDX_W'(0) : IDX_W'(i - 1);
                    r.upper = (i == 0) ? IDX_W'(1) : IDX_W'(i);
                end
            end
        end
        return r;
    endfunction

    function void note_word(logic op, logic [SLOT_W-1:0] slot, logic signed [DATA_W-1:0] value);
        if (op == OP_LOAD)
            breakpoints[slot] = value;
        else
            expected_brackets.push_back(locate(value));
    endfunction

    function void flag(string what);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("MISMATCH: %s", what);
    endfunction

    function void check_bracket(logic [IDX_W-1:0] lower, logic [IDX_W-1:0] upper,
                                logic [STAT_W-1:0] status);
        ibs_result_t want;
        if (expected_brackets.size() == 0)
        begin
            flag($sformatf("unexpected result lower=%0d upper=%0d status=%0d",
                           lower, upper, status));
        end
        else
        begin
            want = expected_brackets.pop_front();
            if (want.lower !== lower || want.upper !== upper || want.status !== status)
                flag($sformatf("expected lower=%0d upper=%0d status=%0d, got lower=%0d upper=%0d status=%0d",
                               want.lower, want.upper, want.status, lower, upper, status));
        end
    endfunction

endclass

module tb_interval_bracket_search_unit;

    localparam int CLK_PERIOD      = 20;
    localparam int SETTLE_CYCLES   = TABLE_SLOTS + 8;
    localparam int ITEM_TARGET     = 1300;
    localparam int WATCHDOG_CYCLES = 600000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    logic                     opcode;
    logic [SLOT_W-1:0]        entry_index;
    logic signed [DATA_W-1:0] sample_value;
    logic                     out_valid;
    logic                     out_ready;
    logic [IDX_W-1:0]         lower_index;
    logic [IDX_W-1:0]         upper_index;
    logic [STAT_W-1:0]        position_status;
    logic                     cfg_write_en;
    logic [CFG_W-1:0]         cfg_write_data;

    bracket_predictor bp = new();
    int               words_sent;
    bit               steady;

    interval_bracket_search_unit #(
        .TABLE_DEPTH(TABLE_SLOTS)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .opcode         (opcode),
        .entry_index    (entry_index),
        .sample_value   (sample_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .lower_index    (lower_index),
        .upper_index    (upper_index),
        .position_status(position_status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(CLK_PERIOD * WATCHDOG_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    // Valid stays high across back-to-back words; here it only drops for a gap.
    task automatic send_word(input logic op, input logic [SLOT_W-1:0] slot,
                             input logic signed [DATA_W-1:0] value);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        entry_index  <= slot;
        sample_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bp.note_word(op, slot, value);
        words_sent++;
    endtask

    task automatic send_query(input logic signed [DATA_W-1:0] value);
        send_word(OP_QUERY, SLOT_W'($urandom_range(0, TABLE_SLOTS - 1)), value);
    endtask

    // A load gives no result, so the engine may still be busy once the last
    // result has come back; wait out a full scan before touching the register.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (bp.expected_brackets.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_entry_count(input logic [CFG_W-1:0] value);
        settle_block();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= value;
        @(negedge clk);
        cfg_write_en <= 1'b0;
        bp.set_entry_count(value);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] count_value);
        int                       n;
        int                       style;
        int                       spread;
        int                       pick;
        int                       tmp;
        int                       words;
        longint                   cur;
        longint                   ceiling;
        int                       order [TABLE_SLOTS];
        logic signed [DATA_W-1:0] vals  [TABLE_SLOTS];
        logic signed [DATA_W-1:0] x;
        write_entry_count(count_value);
        steady = ($urandom_range(0, 3) == 0);
        n      = bp.live_entries();
        style  = $urandom_range(0, 9);
        if (style < 2)
        begin
            for (int i = 0; i < n; i++)
                vals[i] = DATA_W'($urandom_range(0, 200)) - 100;
        end
        else
        begin
            spread  = (style < 5) ? 3 : (style < 8) ? 1000 : (1 << 26);
            cur     = longint'($signed($urandom));
            ceiling = 64'sd2147483647 - longint'(TABLE_SLOTS - 1) * longint'(spread);
            if (cur > ceiling)
                cur = ceiling;
            for (int i = 0; i < n; i++)
            begin
                vals[i] = DATA_W'(cur);
                cur     = cur + longint'($urandom_range(0, spread));
            end
        end
        for (int i = 0; i < n; i++)
            order[i] = i;
        for (int i = n - 1; i > 0; i--)
        begin
            pick     = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[pick];
            order[pick] = tmp;
        end
        for (int i = 0; i < n; i++)
            send_word(OP_LOAD, SLOT_W'(order[i]), vals[order[i]]);

        words = $urandom_range(4, 24);
        for (int w = 0; w < words; w++)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 2)
            begin
                send_word(OP_LOAD, SLOT_W'($urandom_range(0, TABLE_SLOTS - 1)), $urandom);
            end
            else
            begin
                tmp = $urandom_range(0, n - 1);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: x = bp.breakpoints[tmp];
                    4:          x = bp.breakpoints[tmp] + 1;
                    5:          x = bp.breakpoints[tmp] - 1;
                    6:          x = $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
                    default:    x = $urandom;
                endcase
                send_query(x);
            end
        end
    endtask

    initial
    begin : result_sink
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                // Hold ready low until a result word is waiting, then stall on it.
                @(negedge clk);
                out_ready <= 1'b0;
                @(posedge clk);
                while (!out_valid)
                    @(posedge clk);
                repeat (stall) @(negedge clk);
            end
            else
            begin
                @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            bp.check_bracket(lower_index, upper_index, position_status);
        end
    end

    initial
    begin : stimulus
        int             phase;
        logic [CFG_W-1:0] extreme_counts [6];
        logic [CFG_W-1:0] count_value;
        extreme_counts = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd65, 7'd3};
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = OP_LOAD;
        entry_index    = '0;
        sample_value   = '0;
        cfg_write_en   = 1'b0;
        cfg_write_data = ENTRIES_RESET;
        steady         = 1'b0;
        words_sent     = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Two-entry table: full-range extremes, then a table whose minimum
        // equals its maximum.
        write_entry_count(7'd2);
        send_word(OP_LOAD, 6'd0, 32'sh80000000);
        send_word(OP_LOAD, 6'd1, 32'sh7fffffff);
        send_word(OP_LOAD, 6'd63, 32'sh5555aaaa);
        send_query(32'sh80000000);
        send_query(32'sh7fffffff);
        send_query(32'sh00000000);
        send_word(OP_LOAD, 6'd0, 32'sd5);
        send_word(OP_LOAD, 6'd1, 32'sd5);
        send_query(32'sd5);
        send_query(32'sd4);
        send_query(32'sd6);

        // Four entries with a duplicate, then made unsorted so that the
        // first larger entry is entry zero.
        write_entry_count(7'd4);
        send_word(OP_LOAD, 6'd0, -32'sd100);
        send_word(OP_LOAD, 6'd1, 32'sd0);
        send_word(OP_LOAD, 6'd2, 32'sd0);
        send_word(OP_LOAD, 6'd3, 32'sd50);
        send_query(-32'sd100);
        send_query(-32'sd50);
        send_query(32'sd0);
        send_query(32'sd25);
        send_query(32'sd50);
        send_query(32'sd51);
        send_query(-32'sd101);
        send_word(OP_LOAD, 6'd0, 32'sd60);
        send_query(32'sd10);

        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            if (phase < 6)
                count_value = extreme_counts[phase];
            else if ($urandom_range(0, 19) < 14)
                count_value = CFG_W'($urandom_range(2, 10));
            else if ($urandom_range(0, 1) == 0)
                count_value = CFG_W'($urandom_range(0, 127));
            else
                count_value = CFG_W'($urandom_range(11, 64));
            run_phase(count_value);
            phase++;
        end

        settle_block();
        if (bp.mismatch_count == 0 && bp.expected_brackets.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
